>>> hdl/bfknn_pkg.sv
// ============================================================================
// bfknn_pkg - shared types and constants for the k-nearest-neighbour search
// Register map, configuration bundle and default sizes used by all but the queue.
// ============================================================================
`default_nettype none

package bfknn_pkg;

    // default sizes, handed down through top-level parameters
    localparam int MAX_NEIGHBORS_DEF = 32;
    localparam int COORD_BITS_DEF    = 24;
    localparam int INDEX_BITS_DEF    = 20;

    // fixed field widths
    localparam int DIST_W      = 50;
    localparam int CFG_COORD_W = 24;
    localparam int CFG_K_W     = 6;

    // apb port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_QUERY_X          = 2'd0,
        REG_QUERY_Y          = 2'd1,
        REG_QUERY_Z          = 2'd2,
        REG_NEIGHBORS_WANTED = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_COORD_W-1:0] query_x;
        logic [CFG_COORD_W-1:0] query_y;
        logic [CFG_COORD_W-1:0] query_z;
        logic [CFG_K_W-1:0]     neighbors_wanted;
    } cfg_t;

endpackage

`default_nettype wire

>>> hdl/bfknn_front.sv
// ============================================================================
// bfknn_front - candidate intake and squared-distance pipeline
// Two register stages: absolute coordinate differences, then squares; the
// sum of the squares goes to the queue with the candidate's index and flag.
// ============================================================================
`default_nettype none

module bfknn_front #(
    parameter int COORD_BITS = bfknn_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS = bfknn_pkg::INDEX_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire bfknn_pkg::cfg_t              cfg,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [COORD_BITS-1:0] s_cand_x,
    input  wire logic signed [COORD_BITS-1:0] s_cand_y,
    input  wire logic signed [COORD_BITS-1:0] s_cand_z,
    input  wire logic [INDEX_BITS-1:0]        s_cand_index,
    input  wire logic                         s_last_candidate,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [bfknn_pkg::DIST_W-1:0]      out_dist,
    output logic [INDEX_BITS-1:0]             out_index,
    output logic                              out_last
);

    localparam int DW   = COORD_BITS + 1;
    localparam int SQ_W = 2 * DW;

    function automatic logic [DW-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                               input logic [COORD_BITS-1:0] b);
        logic signed [DW-1:0] d;
        d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
        return d[DW-1] ? $unsigned(-d) : $unsigned(d);
    endfunction

    logic                  pipe_en;
    logic                  s1_valid_reg;
    logic [DW-1:0]         s1_abs_x_reg;
    logic [DW-1:0]         s1_abs_y_reg;
    logic [DW-1:0]         s1_abs_z_reg;
    logic [INDEX_BITS-1:0] s1_index_reg;
    logic                  s1_last_reg;
    logic                  s2_valid_reg;
    logic [SQ_W-1:0]       s2_sq_x_reg;
    logic [SQ_W-1:0]       s2_sq_y_reg;
    logic [SQ_W-1:0]       s2_sq_z_reg;
    logic [INDEX_BITS-1:0] s2_index_reg;
    logic                  s2_last_reg;

    // whole pipe stalls while the last stage holds data and the queue is full
    assign pipe_en = !s2_valid_reg || out_ready;
    assign s_ready = pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_abs_x_reg <= abs_diff(cfg.query_x[COORD_BITS-1:0], s_cand_x);
            s1_abs_y_reg <= abs_diff(cfg.query_y[COORD_BITS-1:0], s_cand_y);
            s1_abs_z_reg <= abs_diff(cfg.query_z[COORD_BITS-1:0], s_cand_z);
            s1_index_reg <= s_cand_index;
            s1_last_reg  <= s_last_candidate;
            s2_sq_x_reg  <= s1_abs_x_reg * s1_abs_x_reg;
            s2_sq_y_reg  <= s1_abs_y_reg * s1_abs_y_reg;
            s2_sq_z_reg  <= s1_abs_z_reg * s1_abs_z_reg;
            s2_index_reg <= s1_index_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_dist  = bfknn_pkg::DIST_W'(s2_sq_x_reg) + bfknn_pkg::DIST_W'(s2_sq_y_reg)
                     + bfknn_pkg::DIST_W'(s2_sq_z_reg);
    assign out_index = s2_index_reg;
    assign out_last  = s2_last_reg;

endmodule

`default_nettype wire

>>> hdl/bfknn_queue.sv
// ============================================================================
// bfknn_queue - short queue between distance pipeline and sorted list
// Two-entry first-in first-out buffer so either side can stall on its own.
// ============================================================================
`default_nettype none

module bfknn_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = count_reg < CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/bfknn_back.sv
// ============================================================================
// bfknn_back - sorted neighbour list and result emission
// While running, a row of compare cells inserts one candidate per cycle in
// distance order; on the last one the list shifts out towards cell 0, one result each.
// ============================================================================
`default_nettype none

module bfknn_back #(
    parameter int MAX_NEIGHBORS = bfknn_pkg::MAX_NEIGHBORS_DEF,
    parameter int INDEX_BITS    = bfknn_pkg::INDEX_BITS_DEF,
    parameter int CNT_W         = $clog2(MAX_NEIGHBORS + 1),
    parameter int RANK_W        = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire bfknn_pkg::cfg_t              cfg,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [bfknn_pkg::DIST_W-1:0] in_dist,
    input  wire logic [INDEX_BITS-1:0]        in_index,
    input  wire logic                         in_last,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [RANK_W-1:0]                 m_rank,
    output logic [INDEX_BITS-1:0]             m_neighbor_index,
    output logic [bfknn_pkg::DIST_W-1:0]      m_neighbor_dist_sq,
    output logic [CNT_W-1:0]                  m_found_count,
    output logic [bfknn_pkg::DIST_W-1:0]      m_radius_sq,
    output logic                              m_last_of_run
);

    localparam int DIST_W = bfknn_pkg::DIST_W;

    typedef enum logic [2:0] {
        ST_RUN    = 3'b001,
        ST_RADIUS = 3'b010,
        ST_EMIT   = 3'b100
    } back_state_t;

    back_state_t             state_reg;
    back_state_t             state_next;
    logic [DIST_W-1:0]       cell_dist_reg  [MAX_NEIGHBORS];
    logic [INDEX_BITS-1:0]   cell_index_reg [MAX_NEIGHBORS];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        rank_reg;
    logic [CNT_W-1:0]        rank_next;
    logic [DIST_W-1:0]       radius_reg;
    logic [DIST_W-1:0]       radius_next;
    logic [CNT_W-1:0]        k_eff;
    logic [CNT_W-1:0]        cnt_eff;
    logic [MAX_NEIGHBORS-1:0] gt;
    logic [MAX_NEIGHBORS-1:0] place;
    logic                    enter;
    logic                    insert;
    logic                    shift_out;

    // k of zero acts as one, above the list size as the list size
    always_comb begin
        if (cfg.neighbors_wanted == '0) begin
            k_eff = CNT_W'(1);
        end else if (int'(cfg.neighbors_wanted) > MAX_NEIGHBORS) begin
            k_eff = CNT_W'(MAX_NEIGHBORS);
        end else begin
            k_eff = CNT_W'(cfg.neighbors_wanted);
        end
    end

    // list is cut back if k was lowered since the last candidate
    assign cnt_eff = (count_reg > k_eff) ? k_eff : count_reg;

    always_comb begin
        for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            gt[i]    = (CNT_W'(i) < cnt_eff) && (cell_dist_reg[i] > in_dist);
            place[i] = gt[i] || ((CNT_W'(i) == cnt_eff) && (cnt_eff < k_eff));
        end
    end

    // sorted list: some kept entry is farther exactly when the worst one is
    assign enter     = (cnt_eff < k_eff) || (|gt);
    assign insert    = (state_reg == ST_RUN) && in_valid && enter;
    assign shift_out = (state_reg == ST_EMIT) && m_ready;
    assign in_ready  = state_reg == ST_RUN;

    for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
        logic [DIST_W-1:0]     src_dist;
        logic [INDEX_BITS-1:0] src_index;
        logic [DIST_W-1:0]     up_dist;
        logic [INDEX_BITS-1:0] up_index;

        // farther entries move one place down, the new one lands in the gap
        if (i > 0) begin : g_src
            assign src_dist  = gt[i-1] ? cell_dist_reg[i-1]  : in_dist;
            assign src_index = gt[i-1] ? cell_index_reg[i-1] : in_index;
        end else begin : g_src0
            assign src_dist  = in_dist;
            assign src_index = in_index;
        end

        if (i < MAX_NEIGHBORS - 1) begin : g_up
            assign up_dist  = cell_dist_reg[i+1];
            assign up_index = cell_index_reg[i+1];
        end else begin : g_up_end
            assign up_dist  = cell_dist_reg[i];
            assign up_index = cell_index_reg[i];
        end

        always_ff @(posedge aclk) begin
            if (insert && place[i]) begin
                cell_dist_reg[i]  <= src_dist;
                cell_index_reg[i] <= src_index;
            end else if (shift_out) begin
                cell_dist_reg[i]  <= up_dist;
                cell_index_reg[i] <= up_index;
            end
        end
    end

    // farthest kept entry picked from the tail cell
    always_comb begin
        radius_next = '0;
        for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            if (CNT_W'(i + 1) == count_reg) begin
                radius_next = radius_next | cell_dist_reg[i];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        rank_next  = rank_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (in_valid) begin
                    count_next = cnt_eff + ((cnt_eff < k_eff) ? CNT_W'(1) : CNT_W'(0));
                    if (in_last) begin
                        state_next = ST_RADIUS;
                    end
                end
            end
            ST_RADIUS: begin
                rank_next  = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (m_ready) begin
                    rank_next = rank_reg + CNT_W'(1);
                    if (m_last_of_run) begin
                        count_next = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            count_reg <= '0;
            rank_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RADIUS) begin
            radius_reg <= radius_next;
        end
    end

    assign m_valid            = state_reg == ST_EMIT;
    assign m_rank             = rank_reg[RANK_W-1:0];
    assign m_neighbor_index   = cell_index_reg[0];
    assign m_neighbor_dist_sq = cell_dist_reg[0];
    assign m_found_count      = count_reg;
    assign m_radius_sq        = radius_reg;
    assign m_last_of_run      = CNT_W'(rank_reg + CNT_W'(1)) == count_reg;

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_NEIGHBORS))
        else $error("kept count beyond list size");

    a_rank_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (rank_reg < count_reg))
        else $error("emitting past the end of the list");

    a_cleared_after_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_of_run) |=> (count_reg == '0 && state_reg == ST_RUN))
        else $error("list not cleared after final result");

    a_emit_has_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RADIUS) |-> (count_reg != '0))
        else $error("emission started with an empty list");

    if (MAX_NEIGHBORS > 1) begin : g_sort_check
        a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
            (state_reg == ST_RUN && count_reg >= CNT_W'(2))
                |-> (cell_dist_reg[0] <= cell_dist_reg[1]))
            else $error("list head out of order");
    end

endmodule

`default_nettype wire

>>> hdl/brute_force_k_nearest_neighbors.sv
// ============================================================================
// brute_force_k_nearest_neighbors - streaming k-nearest-neighbour search
// APB registers hold the query point and k; candidates stream in, the k
// nearest leave in rank order after the candidate flagged as last.
// ============================================================================
// A candidate is accepted in every cycle while the two-entry queue behind the
// distance pipeline has room; the squared distance takes two register stages,
// and the sorted list inserts one queued candidate per cycle with a compare
// cell per list entry, so while the list runs a stream goes at one candidate
// per cycle. After the candidate flagged as last, the list picks the radius in
// a state of its own and then gives one result per cycle (found_count results,
// rank 0 first) as the receiver takes them; during emission the list takes no
// candidates, while up to four further candidates wait in the pipeline and
// queue.
// ============================================================================
`default_nettype none

module brute_force_k_nearest_neighbors #(
    parameter int MAX_NEIGHBORS = bfknn_pkg::MAX_NEIGHBORS_DEF,
    parameter int COORD_BITS    = bfknn_pkg::COORD_BITS_DEF,
    parameter int INDEX_BITS    = bfknn_pkg::INDEX_BITS_DEF,
    parameter int CNT_W         = $clog2(MAX_NEIGHBORS + 1),
    parameter int RANK_W        = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [bfknn_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [bfknn_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bfknn_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                      pready,
    // candidates
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [COORD_BITS-1:0]         s_cand_x,
    input  wire logic signed [COORD_BITS-1:0]         s_cand_y,
    input  wire logic signed [COORD_BITS-1:0]         s_cand_z,
    input  wire logic [INDEX_BITS-1:0]                s_cand_index,
    input  wire logic                                 s_last_candidate,
    // neighbour results
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [RANK_W-1:0]                         m_rank,
    output logic [INDEX_BITS-1:0]                     m_neighbor_index,
    output logic [bfknn_pkg::DIST_W-1:0]              m_neighbor_dist_sq,
    output logic [CNT_W-1:0]                          m_found_count,
    output logic [bfknn_pkg::DIST_W-1:0]              m_radius_sq,
    output logic                                      m_last_of_run
);

    localparam int DIST_W  = bfknn_pkg::DIST_W;
    localparam int Q_W     = 1 + INDEX_BITS + DIST_W;
    localparam int CW      = bfknn_pkg::CFG_COORD_W;
    localparam int KW      = bfknn_pkg::CFG_K_W;
    localparam int DATA_W  = bfknn_pkg::APB_DATA_W;
    localparam int ADDR_W  = bfknn_pkg::APB_ADDR_W;

    bfknn_pkg::cfg_t     cfg_reg;
    bfknn_pkg::reg_idx_t reg_idx;
    logic                cfg_wr;

    logic                  f_valid;
    logic                  f_ready;
    logic [DIST_W-1:0]     f_dist;
    logic [INDEX_BITS-1:0] f_index;
    logic                  f_last;
    logic                  q_valid;
    logic                  q_ready;
    logic [Q_W-1:0]        q_data;

    // register file
    assign pready  = 1'b1;
    assign reg_idx = bfknn_pkg::reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.query_x          <= '0;
            cfg_reg.query_y          <= '0;
            cfg_reg.query_z          <= '0;
            cfg_reg.neighbors_wanted <= KW'(1);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                bfknn_pkg::REG_QUERY_X:          cfg_reg.query_x <= pwdata[CW-1:0];
                bfknn_pkg::REG_QUERY_Y:          cfg_reg.query_y <= pwdata[CW-1:0];
                bfknn_pkg::REG_QUERY_Z:          cfg_reg.query_z <= pwdata[CW-1:0];
                bfknn_pkg::REG_NEIGHBORS_WANTED: cfg_reg.neighbors_wanted <= pwdata[KW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bfknn_pkg::REG_QUERY_X:          prdata = DATA_W'(cfg_reg.query_x);
            bfknn_pkg::REG_QUERY_Y:          prdata = DATA_W'(cfg_reg.query_y);
            bfknn_pkg::REG_QUERY_Z:          prdata = DATA_W'(cfg_reg.query_z);
            bfknn_pkg::REG_NEIGHBORS_WANTED: prdata = DATA_W'(cfg_reg.neighbors_wanted);
            default:                         prdata = '0;
        endcase
    end

    bfknn_front #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cand_x         (s_cand_x),
        .s_cand_y         (s_cand_y),
        .s_cand_z         (s_cand_z),
        .s_cand_index     (s_cand_index),
        .s_last_candidate (s_last_candidate),
        .out_valid        (f_valid),
        .out_ready        (f_ready),
        .out_dist         (f_dist),
        .out_index        (f_index),
        .out_last         (f_last)
    );

    bfknn_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_last, f_index, f_dist}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    bfknn_back #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .INDEX_BITS    (INDEX_BITS),
        .CNT_W         (CNT_W),
        .RANK_W        (RANK_W)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg_reg),
        .in_valid           (q_valid),
        .in_ready           (q_ready),
        .in_dist            (q_data[DIST_W-1:0]),
        .in_index           (q_data[DIST_W +: INDEX_BITS]),
        .in_last            (q_data[Q_W-1]),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_rank             (m_rank),
        .m_neighbor_index   (m_neighbor_index),
        .m_neighbor_dist_sq (m_neighbor_dist_sq),
        .m_found_count      (m_found_count),
        .m_radius_sq        (m_radius_sq),
        .m_last_of_run      (m_last_of_run)
    );

endmodule

`default_nettype wire

>>> bench/tb_brute_force_k_nearest_neighbors.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_brute_force_k_nearest_neighbors - self-checking bench for the k-NN search
// Drives candidates and APB writes with random gaps and stalls. Each neighbour
// result is checked against fixed values or an in-bench copy of the sorted list.
// ============================================================================

module tb_brute_force_k_nearest_neighbors;

    localparam int KMAX           = bfknn_pkg::MAX_NEIGHBORS_DEF;
    localparam int CW             = bfknn_pkg::COORD_BITS_DEF;
    localparam int IW             = bfknn_pkg::INDEX_BITS_DEF;
    localparam int DIST_W         = bfknn_pkg::DIST_W;
    localparam int CFG_K_W        = bfknn_pkg::CFG_K_W;
    localparam int APB_ADDR_W     = bfknn_pkg::APB_ADDR_W;
    localparam int APB_DATA_W     = bfknn_pkg::APB_DATA_W;
    localparam int RANDOM_ITEMS   = 410;
    localparam int SETTLE_CYCLES  = 20;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int COORD_MIN      = -8388608;
    localparam int COORD_MAX      = 8388607;

    typedef enum {ROW_CAND, ROW_WRITE} row_kind_t;

    typedef struct packed {
        logic [4:0]        rank;
        logic [IW-1:0]     index;
        logic [DIST_W-1:0] dist_sq;
        logic [5:0]        found;
        logic [DIST_W-1:0] radius_sq;
        logic              last;
    } nbr_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [IW-1:0]        index;
        logic                 last;
    } cand_t;

    typedef struct {
        row_kind_t              kind;
        bfknn_pkg::reg_idx_t    reg_sel;
        logic [APB_DATA_W-1:0]  wdata;
        cand_t                  cand;
        bit                     typed;
        nbr_t                   want;
    } stim_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [CW-1:0]    s_cand_x = '0;
    logic signed [CW-1:0]    s_cand_y = '0;
    logic signed [CW-1:0]    s_cand_z = '0;
    logic [IW-1:0]           s_cand_index = '0;
    logic                    s_last_candidate = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [4:0]              m_rank;
    logic [IW-1:0]           m_neighbor_index;
    logic [DIST_W-1:0]       m_neighbor_dist_sq;
    logic [5:0]              m_found_count;
    logic [DIST_W-1:0]       m_radius_sq;
    logic                    m_last_of_run;

    brute_force_k_nearest_neighbors dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cand_x           (s_cand_x),
        .s_cand_y           (s_cand_y),
        .s_cand_z           (s_cand_z),
        .s_cand_index       (s_cand_index),
        .s_last_candidate   (s_last_candidate),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_rank             (m_rank),
        .m_neighbor_index   (m_neighbor_index),
        .m_neighbor_dist_sq (m_neighbor_dist_sq),
        .m_found_count      (m_found_count),
        .m_radius_sq        (m_radius_sq),
        .m_last_of_run      (m_last_of_run)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // bench copy of the configuration and the sorted neighbour list
    logic signed [CW-1:0] q_x;
    logic signed [CW-1:0] q_y;
    logic signed [CW-1:0] q_z;
    logic [CFG_K_W-1:0]   k_raw;
    logic [DIST_W-1:0]    held_dist [KMAX];
    logic [IW-1:0]        held_index [KMAX];
    int                   held_count;

    nbr_t pending_nbrs[$];
    nbr_t emitted_nbrs[$];
    int   mismatches = 0;
    bit   tx_steady = 1'b0;
    bit   rx_steady = 1'b0;
    bit   squeeze_armed = 1'b0;

    function automatic logic [DIST_W-1:0] dist_to_query(cand_t c);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'(q_x) - longint'(c.x);
        dy = longint'(q_y) - longint'(c.y);
        dz = longint'(q_z) - longint'(c.z);
        return DIST_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    function automatic void rank_candidate(cand_t c);
        int                k_eff;
        int                pos;
        int                j;
        bit                enters;
        logic [DIST_W-1:0] d;
        nbr_t              r;
        k_eff = (k_raw == 0) ? 1 : ((k_raw > KMAX) ? KMAX : int'(k_raw));
        emitted_nbrs.delete();
        // k lowered since the last candidate: drop the tail of the list
        if (held_count > k_eff)
            held_count = k_eff;
        d = dist_to_query(c);
        if (held_count < k_eff)
            enters = 1'b1;
        else
            enters = d < held_dist[held_count - 1];
        if (enters) begin
            pos = 0;
            // equal distances keep arrival order
            while (pos < held_count) begin
                if (held_dist[pos] > d)
                    break;
                pos++;
            end
            if (held_count < k_eff)
                held_count++;
            for (j = held_count - 1; j > pos; j--) begin
                held_dist[j]  = held_dist[j - 1];
                held_index[j] = held_index[j - 1];
            end
            held_dist[pos]  = d;
            held_index[pos] = c.index;
        end
        if (c.last) begin
            for (j = 0; j < held_count; j++) begin
                r.rank      = 5'(j);
                r.index     = held_index[j];
                r.dist_sq   = held_dist[j];
                r.found     = 6'(held_count);
                r.radius_sq = held_dist[held_count - 1];
                r.last      = (j == held_count - 1);
                emitted_nbrs.push_back(r);
            end
            held_count = 0;
        end
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [CW-1:0] jitter(logic signed [CW-1:0] base, int span);
        int off;
        if (span == 0)
            return CW'($urandom);
        off = $urandom_range(0, 2 * span);
        return base + CW'(off - span);
    endfunction

    function automatic logic signed [CW-1:0] pick_coord();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return CW'(COORD_MIN);
        if (roll < 20)
            return CW'(COORD_MAX);
        if (roll < 30)
            return '0;
        if (roll < 65)
            return CW'($urandom);
        return jitter('0, 1000);
    endfunction

    function automatic stim_row_t cand_row(int x, int y, int z, int idx, bit last);
        stim_row_t row;
        row.kind       = ROW_CAND;
        row.reg_sel    = bfknn_pkg::REG_QUERY_X;
        row.wdata      = '0;
        row.cand.x     = CW'(x);
        row.cand.y     = CW'(y);
        row.cand.z     = CW'(z);
        row.cand.index = IW'(idx);
        row.cand.last  = last;
        row.typed      = 1'b0;
        row.want       = '0;
        return row;
    endfunction

    function automatic stim_row_t write_row(bfknn_pkg::reg_idx_t r,
                                            logic [APB_DATA_W-1:0] v);
        stim_row_t row;
        row         = cand_row(0, 0, 0, 0, 1'b0);
        row.kind    = ROW_WRITE;
        row.reg_sel = r;
        row.wdata   = v;
        return row;
    endfunction

    // k = 1 and last set: the single result is the candidate itself
    function automatic stim_row_t single_row(int x, int y, int z, int idx,
                                             logic [DIST_W-1:0] d);
        stim_row_t row;
        row                = cand_row(x, y, z, idx, 1'b1);
        row.typed          = 1'b1;
        row.want.rank      = '0;
        row.want.index     = IW'(idx);
        row.want.dist_sq   = d;
        row.want.found     = 6'd1;
        row.want.radius_sq = d;
        row.want.last      = 1'b1;
        return row;
    endfunction

    function automatic void compare_field(string name, longint unsigned want,
                                          longint unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic write_reg(bfknn_pkg::reg_idx_t r, logic [APB_DATA_W-1:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            bfknn_pkg::REG_QUERY_X:          q_x   = v[CW-1:0];
            bfknn_pkg::REG_QUERY_Y:          q_y   = v[CW-1:0];
            bfknn_pkg::REG_QUERY_Z:          q_z   = v[CW-1:0];
            bfknn_pkg::REG_NEIGHBORS_WANTED: k_raw = v[CFG_K_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_cand(cand_t c, bit typed, nbr_t want);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_cand_x         <= c.x;
        s_cand_y         <= c.y;
        s_cand_z         <= c.z;
        s_cand_index     <= c.index;
        s_last_candidate <= c.last;
        do @(posedge aclk); while (!s_ready);
        rank_candidate(c);
        if (typed)
            pending_nbrs.push_back(want);
        else
            foreach (emitted_nbrs[i])
                pending_nbrs.push_back(emitted_nbrs[i]);
    endtask

    // wait for every neighbour to leave, then let candidates still in flight settle
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_nbrs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // receiver: random stalls, steady stretches, and one long hold-off when armed
    initial begin
        int span;
        int roll;
        bit level;
        forever begin
            @(negedge aclk);
            if (squeeze_armed && m_valid) begin
                squeeze_armed = 1'b0;
                level = 1'b0;
                span  = SQUEEZE_CYCLES;
            end else begin
                roll = $urandom_range(0, 99);
                if (rx_steady || roll < 60) begin
                    level = 1'b1;
                    span  = $urandom_range(1, 8);
                end else begin
                    level = 1'b0;
                    if (roll < 88)
                        span = $urandom_range(1, 3);
                    else if (roll < 97)
                        span = $urandom_range(4, 12);
                    else
                        span = $urandom_range(20, 60);
                end
                if ($urandom_range(0, 31) == 0)
                    rx_steady = !rx_steady;
            end
            m_ready <= level;
            repeat (span - 1) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        nbr_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_nbrs.size() == 0) begin
                $display("%0t: neighbour transaction expected none got rank %0d index %0d",
                         $time, m_rank, m_neighbor_index);
                mismatches++;
            end else begin
                want = pending_nbrs.pop_front();
                compare_field("rank", want.rank, m_rank);
                compare_field("neighbor_index", want.index, m_neighbor_index);
                compare_field("neighbor_dist_sq", want.dist_sq, m_neighbor_dist_sq);
                compare_field("found_count", want.found, m_found_count);
                compare_field("radius_sq", want.radius_sq, m_radius_sq);
                compare_field("last_of_run", want.last, m_last_of_run);
            end
        end
    end

    initial begin
        stim_row_t             directed_rows[$];
        cand_t                 c;
        logic [APB_DATA_W-1:0] v;
        int                    sent;
        int                    phase;
        int                    nq;
        int                    n;
        int                    spread;
        int                    roll;
        bit                    squeeze;

        q_x        = '0;
        q_y        = '0;
        q_z        = '0;
        k_raw      = 6'd1;
        held_count = 0;

        // defaults after reset: query at the origin, k = 1
        directed_rows.push_back(single_row(0, 0, 0, 5, '0));
        directed_rows.push_back(single_row(COORD_MIN, COORD_MIN, COORD_MIN, 'hFFFFF,
                                           50'd211106232532992));
        // opposite corners give the largest distance; upper data bits are ignored
        directed_rows.push_back(write_row(bfknn_pkg::REG_QUERY_X, 32'hA57F_FFFF));
        directed_rows.push_back(write_row(bfknn_pkg::REG_QUERY_Y, 32'h5A7F_FFFF));
        directed_rows.push_back(write_row(bfknn_pkg::REG_QUERY_Z, 32'hFF7F_FFFF));
        directed_rows.push_back(write_row(bfknn_pkg::REG_NEIGHBORS_WANTED, 32'hFFFF_FFC1));
        directed_rows.push_back(single_row(COORD_MIN, COORD_MIN, COORD_MIN, 0,
                                           50'd844424829468675));
        // ties, a full list, an equal-to-worst reject and a replacement
        directed_rows.push_back(write_row(bfknn_pkg::REG_QUERY_X, 32'd100));
        directed_rows.push_back(write_row(bfknn_pkg::REG_QUERY_Y, 32'hFFFF_FF38));
        directed_rows.push_back(write_row(bfknn_pkg::REG_QUERY_Z, 32'd300));
        directed_rows.push_back(write_row(bfknn_pkg::REG_NEIGHBORS_WANTED, 32'd4));
        directed_rows.push_back(cand_row(101, -200, 300, 1, 1'b0));
        directed_rows.push_back(cand_row(100, -199, 300, 2, 1'b0));
        directed_rows.push_back(cand_row(102, -200, 300, 3, 1'b0));
        directed_rows.push_back(cand_row(100, -200, 303, 4, 1'b0));
        directed_rows.push_back(cand_row(103, -200, 300, 5, 1'b0));
        directed_rows.push_back(cand_row(100, -198, 300, 6, 1'b1));
        // k of zero behaves as one
        directed_rows.push_back(write_row(bfknn_pkg::REG_NEIGHBORS_WANTED, 32'h0000_0040));
        directed_rows.push_back(cand_row(100, -200, 305, 7, 1'b0));
        directed_rows.push_back(cand_row(100, -200, 301, 8, 1'b1));
        // k above the array size is clamped, fewer candidates than k
        directed_rows.push_back(write_row(bfknn_pkg::REG_NEIGHBORS_WANTED, 32'd63));
        directed_rows.push_back(cand_row(200, 0, 0, 9, 1'b0));
        directed_rows.push_back(cand_row(COORD_MIN, COORD_MAX, 0, 10, 1'b0));
        directed_rows.push_back(cand_row(100, -200, 300, 11, 1'b1));
        // k lowered part way through a query truncates the list
        directed_rows.push_back(write_row(bfknn_pkg::REG_NEIGHBORS_WANTED, 32'hC000_0005));
        directed_rows.push_back(cand_row(110, -200, 300, 12, 1'b0));
        directed_rows.push_back(cand_row(100, -190, 300, 13, 1'b0));
        directed_rows.push_back(cand_row(100, -200, 301, 14, 1'b0));
        directed_rows.push_back(cand_row(104, -200, 300, 15, 1'b0));
        directed_rows.push_back(write_row(bfknn_pkg::REG_NEIGHBORS_WANTED, 32'd2));
        directed_rows.push_back(cand_row(100, -200, 302, 16, 1'b1));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                drain();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].wdata);
            end else begin
                push_cand(directed_rows[i].cand, directed_rows[i].typed,
                          directed_rows[i].want);
            end
        end

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            drain();
            squeeze = (phase % 5 == 2);
            v = $urandom;
            v[CW-1:0] = pick_coord();
            write_reg(bfknn_pkg::REG_QUERY_X, v);
            v = $urandom;
            v[CW-1:0] = pick_coord();
            write_reg(bfknn_pkg::REG_QUERY_Y, v);
            v = $urandom;
            v[CW-1:0] = pick_coord();
            write_reg(bfknn_pkg::REG_QUERY_Z, v);
            v = $urandom;
            roll = $urandom_range(0, 99);
            if (roll < 15)
                v[CFG_K_W-1:0] = 6'd1;
            else if (roll < 30)
                v[CFG_K_W-1:0] = 6'd32;
            else if (roll < 36)
                v[CFG_K_W-1:0] = 6'd0;
            else if (roll < 42)
                v[CFG_K_W-1:0] = 6'($urandom_range(33, 63));
            else
                v[CFG_K_W-1:0] = 6'($urandom_range(2, (roll < 70) ? 8 : 31));
            write_reg(bfknn_pkg::REG_NEIGHBORS_WANTED, v);

            nq = squeeze ? 3 : $urandom_range(1, 4);
            for (int qi = 0; qi < nq; qi++) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                // hold the receiver on the first query's results while the next streams in
                if (squeeze && qi == 1)
                    squeeze_armed = 1'b1;
                roll = $urandom_range(0, 99);
                if (squeeze)
                    n = $urandom_range(12, 20);
                else if (roll < 70)
                    n = $urandom_range(1, 10);
                else if (roll < 90)
                    n = $urandom_range(11, 24);
                else
                    n = $urandom_range(25, 48);
                spread = $urandom_range(0, 2);
                for (int i = 0; i < n; i++) begin
                    c.x     = jitter(q_x, (spread == 1) ? 3 : 4096 * (spread / 2));
                    c.y     = jitter(q_y, (spread == 1) ? 3 : 4096 * (spread / 2));
                    c.z     = jitter(q_z, (spread == 1) ? 3 : 4096 * (spread / 2));
                    c.index = IW'($urandom);
                    c.last  = (i == n - 1);
                    push_cand(c, 1'b0, '0);
                    sent++;
                end
            end
            phase++;
        end

        drain();
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
